### rtl/core/frame_parity_crc32_check_macros.svh
// Assertion macros shared by the frame check block.
// No dependencies; included by the top level only.
`ifndef FRAME_PARITY_CRC32_CHECK_MACROS_SVH
`define FRAME_PARITY_CRC32_CHECK_MACROS_SVH

// Same-cycle implication under a synchronous active-low reset
`define FPC_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under a synchronous active-low reset
`define FPC_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/fpc_pkg.sv
// Shared types, constants and the CRC byte update for the frame check block.
// No dependencies; the interfaces, the modules and the bench all use it.
package fpc_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CRC_W       = 32;
  localparam logic [CRC_W-1:0] CRC_POLY = 32'h04C1_1DB7;

  // Receive check byte count saturates here
  localparam int unsigned IDX_W       = 3;
  localparam logic [IDX_W-1:0] IDX_MAX = 3'd7;

  // Job queue between front and back; depth is a power of two
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration port
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 2;
  localparam int unsigned MODE_W      = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHECK_MODE = 2'd0,
    REG_DIRECTION  = 2'd1
  } fpc_reg_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_EVEN = 2'd0,
    MODE_ODD  = 2'd1,
    MODE_CRC  = 2'd2
  } fpc_mode_t;

  typedef enum logic {
    DIR_TX = 1'b0,
    DIR_RX = 1'b1
  } fpc_dir_t;

  // Back-end emit phase: the word itself, then four check bytes
  typedef enum logic [2:0] {
    PH_MSG  = 3'd0,
    PH_CHK0 = 3'd1,
    PH_CHK1 = 3'd2,
    PH_CHK2 = 3'd3,
    PH_CHK3 = 3'd4
  } fpc_phase_t;

  // One classified word as handed from front to back
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              chk;
    logic              eof;
    logic              err;
    logic              append;
    logic [CRC_W-1:0]  check_word;
  } fpc_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fpc_q_stat_t;

  typedef struct packed {
    logic pop;
    logic busy;
  } fpc_back_stat_t;

  // Shift one byte into the remainder, MSB first
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    logic             top;
    c = crc;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      top = c[CRC_W-1] ^ b[i];
      c   = {c[CRC_W-2:0], 1'b0} ^ (top ? CRC_POLY : '0);
    end
    return c;
  endfunction

endpackage

### rtl/core/fpc_if.sv
// Channel interfaces for the frame check block: input, result and configuration.
// Depends on fpc_pkg for widths.
interface fpc_in_if;
  logic                        valid;
  logic                        ready;
  logic [fpc_pkg::BYTE_W-1:0]  data_byte;
  logic                        is_check;
  logic                        last_byte;

  modport source (output valid, output data_byte, output is_check,
                  output last_byte, input ready);
  modport sink   (input valid, input data_byte, input is_check,
                  input last_byte, output ready);
endinterface

interface fpc_out_if;
  logic                        valid;
  logic                        ready;
  logic [fpc_pkg::BYTE_W-1:0]  out_byte;
  logic                        out_is_check;
  logic                        end_of_frame;
  logic                        error_found;

  modport source (output valid, output out_byte, output out_is_check,
                  output end_of_frame, output error_found, input ready);
  modport sink   (input valid, input out_byte, input out_is_check,
                  input end_of_frame, input error_found, output ready);
endinterface

interface fpc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [fpc_pkg::CFG_IDX_W-1:0]   index;
  logic [fpc_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/fpc_front.sv
// Front end: configuration registers, input acceptance, CRC and parity update,
// and classification of each word into a job. Depends on fpc_pkg and fpc_if.
module fpc_front (
  input  logic              clk,
  input  logic              rst_n,
  fpc_cfg_if.sink           cfg_ch,
  fpc_in_if.sink            in_ch,
  input  logic              q_full,
  output logic              push,
  output fpc_pkg::fpc_job_t job
);
  import fpc_pkg::*;

  logic [MODE_W-1:0] mode_r;
  fpc_dir_t          dir_r;
  logic [CRC_W-1:0]  crc_r, crc_nxt;
  logic              par_r, par_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              rpb_r, rpb_nxt;

  logic [CRC_W-1:0]  crc_new;
  logic              par_new;
  logic              crc_mode;
  logic              odd;
  logic              accept;

  // Configuration is always taken
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_CRC;
      dir_r  <= DIR_TX;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_CHECK_MODE: mode_r <= cfg_ch.data[MODE_W-1:0];
        REG_DIRECTION:  dir_r  <= fpc_dir_t'(cfg_ch.data[0]);
        default: ;
      endcase
    end
  end

  assign crc_mode    = mode_r[1];
  assign odd         = (mode_r == MODE_ODD);
  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push        = accept;

  assign crc_new = crc_byte(crc_r, in_ch.data_byte);
  assign par_new = par_r ^ (^in_ch.data_byte);

  // Classify the word and work out the frame state after it
  always_comb begin
    crc_nxt        = crc_new;
    par_nxt        = par_r;
    idx_nxt        = idx_r;
    rpb_nxt        = rpb_r;
    job.data       = in_ch.data_byte;
    job.chk        = 1'b0;
    job.eof        = 1'b0;
    job.err        = 1'b0;
    job.append     = 1'b0;
    job.check_word = '0;
    if (dir_r == DIR_TX) begin
      par_nxt        = par_new;
      job.append     = in_ch.last_byte;
      job.check_word = crc_mode ? crc_new : {par_new ^ odd, {(CRC_W-1){1'b0}}};
    end else begin
      job.chk = in_ch.is_check;
      job.eof = in_ch.last_byte;
      if (in_ch.is_check) begin
        if (idx_r == '0) begin
          rpb_nxt = in_ch.data_byte[BYTE_W-1];
        end
        if (idx_r != IDX_MAX) begin
          idx_nxt = idx_r + 1'b1;
        end
      end else begin
        par_nxt = par_new;
      end
      if (in_ch.last_byte) begin
        job.err = crc_mode ? (crc_new != '0) : ((par_nxt ^ odd) != rpb_nxt);
      end
    end
    // Clear the CRC, parity and check byte count at frame end
    if (in_ch.last_byte) begin
      crc_nxt = '0;
      par_nxt = 1'b0;
      idx_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= '0;
      par_r <= 1'b0;
      idx_r <= '0;
      rpb_r <= 1'b0;
    end else if (accept) begin
      crc_r <= crc_nxt;
      par_r <= par_nxt;
      idx_r <= idx_nxt;
      rpb_r <= rpb_nxt;
    end
  end

endmodule

### rtl/core/fpc_queue.sv
// Short job queue between front and back end.
// Depends on fpc_pkg for the job type and depth.
module fpc_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  fpc_pkg::fpc_job_t    push_job,
  input  logic                 pop,
  output fpc_pkg::fpc_job_t    head_job,
  output fpc_pkg::fpc_q_stat_t stat
);
  import fpc_pkg::*;

  fpc_job_t          entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign head_job   = entries_r[rd_ptr_r];

  // Store the pushed job
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_job;
    end
  end

  // Advance pointers and the fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

### rtl/core/fpc_back.sv
// Back end: expands each job into result words and drives the output register.
// Depends on fpc_pkg and fpc_if.
module fpc_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  fpc_pkg::fpc_job_t       job,
  input  fpc_pkg::fpc_q_stat_t    q_stat,
  output fpc_pkg::fpc_back_stat_t stat,
  fpc_out_if.source               out_ch
);
  import fpc_pkg::*;

  fpc_phase_t        phase_r, phase_nxt;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_chk_r, out_chk_nxt;
  logic              out_eof_r, out_eof_nxt;
  logic              out_err_r, out_err_nxt;
  logic              load;
  logic              step;
  logic              job_done;

  assign load = !out_valid_r || out_ch.ready;
  assign step = load && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MSG;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  // Pick the result word for this phase and the phase after it
  always_comb begin
    out_byte_nxt = job.data;
    out_chk_nxt  = 1'b1;
    out_eof_nxt  = 1'b0;
    out_err_nxt  = 1'b0;
    job_done     = 1'b0;
    unique case (phase_r)
      PH_MSG: begin
        out_chk_nxt = job.chk;
        out_eof_nxt = job.eof;
        out_err_nxt = job.err;
        job_done    = !job.append;
      end
      PH_CHK0: out_byte_nxt = job.check_word[31:24];
      PH_CHK1: out_byte_nxt = job.check_word[23:16];
      PH_CHK2: out_byte_nxt = job.check_word[15:8];
      PH_CHK3: begin
        out_byte_nxt = job.check_word[7:0];
        out_eof_nxt  = 1'b1;
        job_done     = 1'b1;
      end
      default: job_done = 1'b1;
    endcase
    phase_nxt = phase_r;
    if (step) begin
      phase_nxt = job_done ? PH_MSG : fpc_phase_t'(phase_r + 1'b1);
    end
  end

  assign stat.pop  = step && job_done;
  assign stat.busy = (phase_r != PH_MSG);

  // Hold the result until taken, load the next when free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= !q_stat.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_byte_r <= out_byte_nxt;
      out_chk_r  <= out_chk_nxt;
      out_eof_r  <= out_eof_nxt;
      out_err_r  <= out_err_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_byte     = out_byte_r;
  assign out_ch.out_is_check = out_chk_r;
  assign out_ch.end_of_frame = out_eof_r;
  assign out_ch.error_found  = out_err_r;

endmodule

### rtl/core/frame_parity_crc32_check.sv
// Channel    Dir  Payload                                           Handshake
// cfg_ch     in   index, data (check_mode, direction)               valid/ready
// in_ch      in   data_byte, is_check, last_byte                    valid/ready
// out_ch     out  out_byte, out_is_check, end_of_frame, error_found valid/ready
//
// One input word per cycle while the queue is not full; the front end folds the CRC in byte-wide.
// A transmit last word yields five results, so the back end's output register
// sets the pace for that word.
// Synchronous active-low reset clears config to CRC transmit and empties the queue.
// A stalled output fills the two-entry queue, then in_ch.ready drops.
// Top level of the frame check block; depends on fpc_pkg, fpc_if and the macros header.
module frame_parity_crc32_check (
  input  logic     clk,
  input  logic     rst_n,
  fpc_cfg_if.sink  cfg_ch,
  fpc_in_if.sink   in_ch,
  fpc_out_if.source out_ch
);
  import fpc_pkg::*;

  `include "frame_parity_crc32_check_macros.svh"

  logic           q_push;
  logic           q_pop;
  fpc_job_t       push_job;
  fpc_job_t       head_job;
  fpc_q_stat_t    q_stat;
  fpc_back_stat_t back_stat;

  fpc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .q_full (q_stat.full),
    .push   (q_push),
    .job    (push_job)
  );

  fpc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .stat     (q_stat)
  );

  fpc_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .job    (head_job),
    .q_stat (q_stat),
    .stat   (back_stat),
    .out_ch (out_ch)
  );

  assign q_pop = back_stat.pop;

  // Checks on the block's own logic
  `FPC_ASSERT_IMP(a_err_at_eof, clk, rst_n, out_ch.valid && out_ch.error_found, out_ch.end_of_frame, "error flag off frame end")
  `FPC_ASSERT_IMP(a_pop_nonempty, clk, rst_n, back_stat.pop, !q_stat.empty, "pop from empty queue")
  `FPC_ASSERT_IMP(a_busy_has_job, clk, rst_n, back_stat.busy, !q_stat.empty, "check bytes without a job")
  `FPC_ASSERT_NXT(a_full_blocks, clk, rst_n, q_stat.full && !back_stat.pop, !in_ch.ready, "input taken into full queue")

endmodule

### dv/testbench.sv
// Self-checking bench for frame_parity_crc32_check: a directed table, then random frames.
// Depends on fpc_pkg and the channel interfaces in fpc_if; drives the block through them.
// A word-level predictor keeps its own copy of the check state and config.
module testbench;
  import fpc_pkg::*;

  localparam int unsigned CHECK_BYTES   = 4;
  localparam int unsigned RANDOM_WORDS  = 180;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_CYCLES  = 20;
  localparam int unsigned LONG_HOLD     = 80;
  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned PRINT_CAP     = 40;
  localparam int unsigned N_DIRECTED    = 34;

  // Register indexes past the two real ones, and the spare mode value
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
  localparam logic [MODE_W-1:0]    MODE_CRC_ALT = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              chk;
    logic              eof;
    logic              err;
  } frame_word_t;

  typedef struct packed {
    logic        on;
    frame_word_t want;
  } pinned_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              chk;
  } raw_word_t;

  typedef enum logic {
    ROW_WORD = 1'b0,
    ROW_CFG  = 1'b1
  } row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic [BYTE_W-1:0]     data;
    logic                  chk;
    logic                  last;
    logic                  typed;
    frame_word_t           want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  fpc_cfg_if cfg_ch ();
  fpc_in_if  in_ch ();
  fpc_out_if out_ch ();

  frame_parity_crc32_check u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #6 clk = ~clk;

  // Predicted state of the block
  logic [MODE_W-1:0] cur_mode        = MODE_CRC;
  fpc_dir_t          cur_dir         = DIR_TX;
  logic [CRC_W-1:0]  crc_acc         = '0;
  logic              msg_parity      = 1'b0;
  logic [IDX_W-1:0]  chk_count       = '0;
  logic              held_parity_bit = 1'b0;

  frame_word_t  expected_words[$];
  pinned_word_t pinned_firsts[$];
  raw_word_t    frame_buf[$];

  int          mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int          random_words   = 0;
  int          hold_asks      = 0;
  int          hold_done      = 0;
  bit          in_free        = 1'b0;
  bit          out_free       = 1'b0;

  stim_row_t directed_rows [0:N_DIRECTED-1];

  task automatic flag_mismatch(input string what);
    if (mismatch_count < PRINT_CAP) $display("[%0t] check failed: %s", $time, what);
    mismatch_count++;
  endtask

  // Fold one byte into the remainder, MSB first
  function automatic logic [CRC_W-1:0] crc32_shift_byte(input logic [CRC_W-1:0] acc,
                                                        input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] r;
    logic             fb;
    r = acc;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      fb = r[CRC_W-1] ^ b[i];
      r  = r << 1;
      if (fb) r = r ^ CRC_POLY;
    end
    return r;
  endfunction

  // Work out the result words caused by one accepted input word
  task automatic predict_frame_word(input logic [BYTE_W-1:0] b, input logic chk,
                                    input logic last);
    logic        odd_sel;
    frame_word_t w;
    odd_sel = (cur_mode == MODE_ODD);
    crc_acc = crc32_shift_byte(crc_acc, b);
    if (cur_dir == DIR_TX) begin
      msg_parity = msg_parity ^ (^b);
      w = '{b, 1'b0, 1'b0, 1'b0};
      expected_words.insert(expected_words.size(), w);
      if (last) begin
        for (int k = 0; k < CHECK_BYTES; k++) begin
          if (cur_mode[1]) w.data = crc_acc[8*(CHECK_BYTES-1-k) +: 8];
          else w.data = (k == 0) ? {msg_parity ^ odd_sel, 7'b0} : 8'h00;
          w.chk = 1'b1;
          w.eof = (k == CHECK_BYTES - 1);
          w.err = 1'b0;
          expected_words.insert(expected_words.size(), w);
        end
        crc_acc    = '0;
        msg_parity = 1'b0;
        chk_count  = '0;
      end
    end else begin
      if (chk) begin
        if (chk_count == '0) held_parity_bit = b[7];
        if (chk_count != IDX_MAX) chk_count = chk_count + 3'd1;
      end else begin
        msg_parity = msg_parity ^ (^b);
      end
      w = '{b, chk, last, 1'b0};
      if (last) begin
        if (cur_mode[1]) w.err = (crc_acc != '0);
        else w.err = ((msg_parity ^ odd_sel) != held_parity_bit);
        crc_acc    = '0;
        msg_parity = 1'b0;
        chk_count  = '0;
      end
      expected_words.insert(expected_words.size(), w);
    end
  endtask

  // Monitor: track config, predict on accepted words, compare results
  frame_word_t  want_w;
  pinned_word_t pin;
  int           base_idx;

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == REG_CHECK_MODE) cur_mode = cfg_ch.data;
        else if (cfg_ch.index == REG_DIRECTION) cur_dir = fpc_dir_t'(cfg_ch.data[0]);
      end
      if (in_ch.valid && in_ch.ready) begin
        base_idx = expected_words.size();
        predict_frame_word(in_ch.data_byte, in_ch.is_check, in_ch.last_byte);
        if (pinned_firsts.size() != 0) begin
          pin = pinned_firsts.pop_front();
          if (pin.on) expected_words[base_idx] = pin.want;
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          flag_mismatch($sformatf("unexpected word %02h", out_ch.out_byte));
        end else begin
          want_w = expected_words.pop_front();
          if (out_ch.out_byte !== want_w.data)
            flag_mismatch($sformatf("out_byte %02h, want %02h", out_ch.out_byte, want_w.data));
          if (out_ch.out_is_check !== want_w.chk)
            flag_mismatch($sformatf("out_is_check %b, want %b (byte %02h)",
                                    out_ch.out_is_check, want_w.chk, want_w.data));
          if (out_ch.end_of_frame !== want_w.eof)
            flag_mismatch($sformatf("end_of_frame %b, want %b (byte %02h)",
                                    out_ch.end_of_frame, want_w.eof, want_w.data));
          if (out_ch.error_found !== want_w.err)
            flag_mismatch($sformatf("error_found %b, want %b (byte %02h)",
                                    out_ch.error_found, want_w.err, want_w.data));
        end
      end
    end
  end

  // Give up on a hung block
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: random ready, with a long hold-off when asked
  initial begin : out_ready_driver
    int roll;
    int run;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asks != hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_done++;
      end else if (out_free) begin
        out_ch.ready <= 1'b1;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 65) begin
          out_ch.ready <= 1'b1;
          run = $urandom_range(1, 8);
        end else if (roll < 95) begin
          out_ch.ready <= 1'b0;
          run = $urandom_range(1, 3);
        end else begin
          out_ch.ready <= 1'b0;
          run = $urandom_range(10, 40);
        end
        repeat (run - 1) @(negedge clk);
      end
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (in_free || roll < 60) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one word after a random gap and hold it until taken
  task automatic send_word(input logic [BYTE_W-1:0] d, input logic c, input logic l,
                           input logic typed, input frame_word_t want);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= d;
    in_ch.is_check  <= c;
    in_ch.last_byte <= l;
    pinned_firsts.insert(pinned_firsts.size(), '{typed, want});
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Drop valid and wait until every expected word is out
  task automatic settle_block();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    settle_block();
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] val);
    cfg_row         = '0;
    cfg_row.kind    = ROW_CFG;
    cfg_row.reg_idx = idx;
    cfg_row.reg_val = val;
  endfunction

  function automatic stim_row_t word_row(input logic [BYTE_W-1:0] d, input logic c,
                                         input logic l);
    word_row      = '0;
    word_row.kind = ROW_WORD;
    word_row.data = d;
    word_row.chk  = c;
    word_row.last = l;
  endfunction

  // Word whose first result is spelt out: echoed byte plus the given flags
  function automatic stim_row_t known_row(input logic [BYTE_W-1:0] d, input logic c,
                                          input logic l, input logic w_chk,
                                          input logic w_eof, input logic w_err);
    known_row       = word_row(d, c, l);
    known_row.typed = 1'b1;
    known_row.want  = '{d, w_chk, w_eof, w_err};
  endfunction

  task automatic build_tx_frame();
    int n;
    frame_buf.delete();
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
    repeat (n)
      frame_buf.insert(frame_buf.size(),
                       '{8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))});
  endtask

  // Mostly well-formed receive frames; some damaged, short, padded or pure noise
  task automatic build_rx_frame(input logic [MODE_W-1:0] mode);
    int                n;
    int                roll;
    int                pos;
    logic [BYTE_W-1:0] b;
    logic [CRC_W-1:0]  acc;
    logic              par;
    frame_buf.delete();
    acc  = '0;
    par  = 1'b0;
    roll = $urandom_range(0, 99);
    n    = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
    if (roll >= 93) begin
      repeat (n)
        frame_buf.insert(frame_buf.size(),
                         '{8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))});
    end else begin
      repeat (n) begin
        b   = 8'($urandom_range(0, 255));
        acc = crc32_shift_byte(acc, b);
        par = par ^ (^b);
        frame_buf.insert(frame_buf.size(), '{b, 1'b0});
      end
      if (roll < 75 || roll >= 85) begin
        for (int k = 0; k < CHECK_BYTES; k++) begin
          if (mode[1]) b = acc[8*(CHECK_BYTES-1-k) +: 8];
          else if (k == 0) b = {par ^ (mode == MODE_ODD), 7'($urandom_range(0, 127))};
          else b = 8'($urandom_range(0, 255));
          frame_buf.insert(frame_buf.size(), '{b, 1'b1});
        end
      end
      // pad with surplus check bytes
      if (roll >= 85)
        repeat ($urandom_range(1, 6))
          frame_buf.insert(frame_buf.size(), '{8'($urandom_range(0, 255)), 1'b1});
      // flip one bit somewhere in the frame
      if (roll >= 60 && roll < 75) begin
        pos = $urandom_range(0, frame_buf.size() - 1);
        frame_buf[pos].data = frame_buf[pos].data ^ 8'(1 << $urandom_range(0, 7));
      end
    end
  endtask

  task automatic send_frame_buf();
    for (int i = 0; i < frame_buf.size(); i++) begin
      send_word(frame_buf[i].data, frame_buf[i].chk, (i == frame_buf.size() - 1), 1'b0, '0);
      random_words++;
    end
  endtask

  initial begin : stimulus
    logic [MODE_W-1:0] ph_mode;
    fpc_dir_t          ph_dir;
    int                phase;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.is_check  = 1'b0;
    in_ch.last_byte = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = '0;
    cfg_ch.data     = '0;

    directed_rows = '{
      // reset config: CRC transmit; is_check is ignored here
      known_row(8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0),
      word_row (8'hA5, 1'b0, 1'b1),
      cfg_row  (REG_CHECK_MODE, MODE_EVEN),
      known_row(8'hFF, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0),
      word_row (8'h01, 1'b0, 1'b1),
      cfg_row  (REG_CHECK_MODE, MODE_ODD),
      word_row (8'h01, 1'b1, 1'b1),
      word_row (8'h00, 1'b0, 1'b1),
      // spare mode value behaves as CRC; spare index is a no-op
      cfg_row  (REG_CHECK_MODE, MODE_CRC_ALT),
      cfg_row  (REG_SPARE_HI, 2'b01),
      cfg_row  (REG_DIRECTION, {1'b0, DIR_RX}),
      // 0x01 followed by its own remainder checks clean
      word_row (8'h01, 1'b0, 1'b0),
      word_row (8'h04, 1'b1, 1'b0),
      word_row (8'hC1, 1'b1, 1'b0),
      word_row (8'h1D, 1'b1, 1'b0),
      known_row(8'hB7, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0),
      known_row(8'h01, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1),
      // nine check bytes: count saturates, only the first sets the parity bit
      cfg_row  (REG_CHECK_MODE, MODE_EVEN),
      word_row (8'h00, 1'b0, 1'b0),
      word_row (8'h00, 1'b1, 1'b0),
      word_row (8'h80, 1'b1, 1'b0),
      word_row (8'h80, 1'b1, 1'b0),
      word_row (8'h80, 1'b1, 1'b0),
      word_row (8'h80, 1'b1, 1'b0),
      word_row (8'h80, 1'b1, 1'b0),
      word_row (8'h80, 1'b1, 1'b0),
      word_row (8'h80, 1'b1, 1'b0),
      known_row(8'h80, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0),
      // frame with no check byte compares against the held parity bit
      known_row(8'h01, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1),
      cfg_row  (REG_CHECK_MODE, MODE_ODD),
      word_row (8'h00, 1'b0, 1'b0),
      known_row(8'h80, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0),
      // direction value is masked to one bit, so this lands on transmit
      cfg_row  (REG_DIRECTION, 2'b10),
      known_row(8'h3C, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0)
    };

    // Hold the synchronous reset, then release it
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    for (int r = 0; r < N_DIRECTED; r++) begin
      if (directed_rows[r].kind == ROW_CFG)
        write_register(directed_rows[r].reg_idx, directed_rows[r].reg_val);
      else
        send_word(directed_rows[r].data, directed_rows[r].chk, directed_rows[r].last,
                  directed_rows[r].typed, directed_rows[r].want);
    end

    // Random phases, each with its own config and idling pattern
    phase = 0;
    while (random_words < RANDOM_WORDS) begin
      ph_mode = 2'($urandom_range(0, 3));
      ph_dir  = $urandom_range(0, 1) ? DIR_RX : DIR_TX;
      write_register(REG_CHECK_MODE, ph_mode);
      write_register(REG_DIRECTION, {1'b0, ph_dir});
      if ($urandom_range(0, 3) == 0)
        write_register($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
                       2'($urandom_range(0, 3)));
      in_free  = ($urandom_range(0, 3) == 0) || (phase == 1);
      out_free = ($urandom_range(0, 3) == 0) && (phase != 1);
      // back up the block once: stall results while words keep coming
      if (phase == 1) hold_asks++;
      repeat ($urandom_range(3, 6)) begin
        if (ph_dir == DIR_TX) build_tx_frame();
        else build_rx_frame(ph_mode);
        send_frame_buf();
      end
      phase++;
    end

    // Drain and give the verdict
    in_free  = 1'b0;
    out_free = 1'b0;
    settle_block();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/fpc_pkg.sv
rtl/core/fpc_if.sv
rtl/core/fpc_front.sv
rtl/core/fpc_queue.sv
rtl/core/fpc_back.sv
rtl/core/frame_parity_crc32_check.sv
dv/testbench.sv
